@@ design/assert_macros.svh @@
// Assertion macros shared by the sponge hash RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define ASSERT_SYNC(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_SYNC(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ design/sks_pkg.sv @@
// Shared types and constants for the Keccak sponge hash.
package sks_pkg;

  localparam int LANES   = 25;
  localparam int LANE_W  = 64;
  localparam int STATE_W = LANES * LANE_W;
  localparam int ROUNDS  = 24;
  localparam int RND_W   = 5;

  localparam logic [7:0] RATE_MIN     = 8'd8;
  localparam logic [7:0] RATE_MAX     = 8'd168;
  localparam logic [7:0] RATE_RST     = 8'd136;
  localparam logic [6:0] OUTB_RST     = 7'd32;
  localparam logic [7:0] SUFFIX_RST   = 8'h06;
  localparam logic [7:0] PAD_BYTE     = 8'h80;
  localparam logic [7:0] LFSR_TAPS    = 8'h71;
  localparam logic [7:0] LFSR_SEED    = 8'h01;
  localparam int         MAX_DIGEST_BYTES_DEF = 64;

  typedef enum logic [1:0] {
    CMD_ABSORB  = 2'd0,
    CMD_ABS_FIN = 2'd1,
    CMD_FINAL   = 2'd2,
    CMD_NONE    = 2'd3
  } sks_cmd_t;

  typedef enum logic [1:0] {
    CFG_RATE   = 2'd0,
    CFG_OUTB   = 2'd1,
    CFG_SUFFIX = 2'd2
  } sks_cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_PAD,
    ST_PAD_END,
    ST_PERM,
    ST_SQUEEZE
  } sks_fsm_t;

  // Sequencer control toward the round-constant generator.
  typedef struct packed {
    logic seed;
    logic step;
  } sks_rc_ctrl_t;

endpackage

@@ design/sks_rc_lfsr.sv @@
// Round-constant generator: degree-8 LFSR, seven steps per round.
module sks_rc_lfsr (
  input  logic                clk,
  input  logic                rst_n,
  input  sks_pkg::sks_rc_ctrl_t ctrl,
  output logic [63:0]         rc
);
  import sks_pkg::*;

  logic [7:0] lfsr_r, lfsr_nxt, walk;

  always_comb begin
    walk = lfsr_r;
    rc   = '0;
    for (int j = 0; j < 7; j++) begin
      rc[(1 << j) - 1] = walk[0];
      walk = walk[7] ? ({walk[6:0], 1'b0} ^ LFSR_TAPS) : {walk[6:0], 1'b0};
    end
  end

  always_comb begin
    lfsr_nxt = lfsr_r;
    if (ctrl.seed) begin
      lfsr_nxt = LFSR_SEED;
    end else if (ctrl.step) begin
      lfsr_nxt = walk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= LFSR_SEED;
    end else begin
      lfsr_r <= lfsr_nxt;
    end
  end

endmodule

@@ design/sks_round.sv @@
// One Keccak-f[1600] round: theta, rho, pi, chi, iota.
module sks_round (
  input  logic [sks_pkg::STATE_W-1:0] state_in,
  input  logic [63:0]                 rc,
  output logic [sks_pkg::STATE_W-1:0] state_out
);
  import sks_pkg::*;

  // rho offsets, indexed x + 5y
  localparam logic [5:0] RHO_OFF [LANES] = '{
    6'd0,  6'd1,  6'd62, 6'd28, 6'd27,
    6'd36, 6'd44, 6'd6,  6'd55, 6'd20,
    6'd3,  6'd10, 6'd43, 6'd25, 6'd39,
    6'd41, 6'd45, 6'd15, 6'd21, 6'd8,
    6'd18, 6'd2,  6'd61, 6'd56, 6'd14
  };

  logic [63:0] a   [LANES];
  logic [63:0] b   [LANES];
  logic [63:0] par [5];
  logic [63:0] d   [5];
  logic [63:0] t;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      a[i] = state_in[i*LANE_W +: LANE_W];
    end
    for (int x = 0; x < 5; x++) begin
      par[x] = a[x] ^ a[x+5] ^ a[x+10] ^ a[x+15] ^ a[x+20];
    end
    for (int x = 0; x < 5; x++) begin
      d[x] = par[(x+4)%5] ^ {par[(x+1)%5][62:0], par[(x+1)%5][63]};
    end
    for (int x = 0; x < 5; x++) begin
      for (int y = 0; y < 5; y++) begin
        t = a[x+5*y] ^ d[x];
        if (RHO_OFF[x+5*y] == 6'd0) begin
          b[y+5*((2*x+3*y)%5)] = t;
        end else begin
          b[y+5*((2*x+3*y)%5)] = (t << RHO_OFF[x+5*y]) |
                                 (t >> (7'd64 - {1'b0, RHO_OFF[x+5*y]}));
        end
      end
    end
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        state_out[(x+5*y)*LANE_W +: LANE_W] =
          b[x+5*y] ^ (~b[(x+1)%5+5*y] & b[(x+2)%5+5*y]);
      end
    end
    state_out[LANE_W-1:0] = state_out[LANE_W-1:0] ^ rc;
  end

endmodule

@@ design/sha3_keccak_sponge_hash.sv @@
// Keccak sponge hash top level: sequencer, state register and byte ports.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in_     | slave     | in_tvalid/in_tready  | tuser: command, tdata: data_byte
//  out_    | master    | out_tvalid/out_tready| tdata: digest_byte, tlast: last
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// An absorbed byte is accepted, then XORed into the state. Each
// permutation is 24 rounds, one round per cycle through the single
// round unit; one runs per full rate block absorbed. Finalize adds the
// ST_PAD and ST_PAD_END steps, one or two permutations, then one digest byte
// per cycle while out_tready is high, plus a turnaround and 24 rounds per
// further rate block squeezed.
// Reset: rst_n synchronous, active low; clears state and fill, config to defaults.
// Stalls: in_tready is low while an item is in work; the output register
// holds a byte until taken, and squeezing waits on it. cfg is always ready.
module sha3_keccak_sponge_hash #(
  parameter int MAX_DIGEST_BYTES = sks_pkg::MAX_DIGEST_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [1:0] in_tuser,    // [1:0] command
  input  logic [7:0] in_tdata,    // [7:0] data_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] digest_byte
  output logic       out_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import sks_pkg::*;

  localparam logic [6:0] OUTB_CAP = 7'(MAX_DIGEST_BYTES);

  sks_fsm_t           fsm_r, fsm_nxt, ret_r, ret_nxt;
  logic [STATE_W-1:0] lanes_r, lanes_nxt, round_out;
  logic [7:0]         rate_r, suffix_r, fill_r, fill_nxt, idx_r, idx_nxt;
  logic [6:0]         outb_r, k_r, k_nxt;
  sks_cmd_t           cmd_r, cmd_nxt;
  logic [7:0]         data_r, data_nxt;
  logic [RND_W-1:0]   round_r, round_nxt;
  logic               out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [7:0]         out_data_r, out_data_nxt;
  logic [7:0]         rate_eff;
  logic [6:0]         n_eff;
  logic               in_acc, slot_free, fill_wrap, sq_last, sq_load;
  logic [63:0]        rc;
  sks_rc_ctrl_t       rc_ctrl;

  assign in_tready  = (fsm_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign rate_eff  = (rate_r < RATE_MIN) ? RATE_MIN :
                     (rate_r > RATE_MAX) ? RATE_MAX : rate_r;
  assign n_eff     = (outb_r == 7'd0) ? 7'd1 :
                     (outb_r > OUTB_CAP) ? OUTB_CAP : outb_r;
  assign slot_free = !out_valid_r || out_tready;
  assign fill_wrap = ({1'b0, fill_r} + 9'd1) >= {1'b0, rate_eff};
  assign sq_last   = (k_r + 7'd1) == n_eff;
  assign sq_load   = (fsm_r == ST_SQUEEZE) && (idx_r != rate_eff) && slot_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r   <= RATE_RST;
      outb_r   <= OUTB_RST;
      suffix_r <= SUFFIX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sks_cfg_idx_t'(cfg_index))
        CFG_RATE:   rate_r   <= cfg_data;
        CFG_OUTB:   outb_r   <= cfg_data[6:0];
        CFG_SUFFIX: suffix_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: next state and return point after a permutation
  always_comb begin
    fsm_nxt = fsm_r;
    ret_nxt = ret_r;
    unique case (fsm_r)
      ST_IDLE: begin
        if (in_acc && (sks_cmd_t'(in_tuser) != CMD_NONE)) begin
          if (fill_r >= rate_eff) begin
            fsm_nxt = ST_PERM;
            ret_nxt = ST_ABSORB;
          end else begin
            fsm_nxt = ST_ABSORB;
          end
        end
      end
      ST_ABSORB: begin
        if (cmd_r == CMD_FINAL) begin
          fsm_nxt = ST_PAD;
        end else if (fill_wrap) begin
          fsm_nxt = ST_PERM;
          ret_nxt = (cmd_r == CMD_ABSORB) ? ST_IDLE : ST_PAD;
        end else begin
          fsm_nxt = (cmd_r == CMD_ABSORB) ? ST_IDLE : ST_PAD;
        end
      end
      ST_PAD: begin
        // suffix top bit in the last rate byte: permute before the pad bit
        if (suffix_r[7] && (fill_r == rate_eff - 8'd1)) begin
          fsm_nxt = ST_PERM;
          ret_nxt = ST_PAD_END;
        end else begin
          fsm_nxt = ST_PAD_END;
        end
      end
      ST_PAD_END: begin
        fsm_nxt = ST_PERM;
        ret_nxt = ST_SQUEEZE;
      end
      ST_PERM: begin
        if (round_r == RND_W'(ROUNDS - 1)) begin
          fsm_nxt = ret_r;
        end
      end
      ST_SQUEEZE: begin
        if (idx_r == rate_eff) begin
          fsm_nxt = ST_PERM;
          ret_nxt = ST_SQUEEZE;
        end else if (slot_free && sq_last) begin
          fsm_nxt = ST_IDLE;
        end
      end
      default: fsm_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: datapath updates
  always_comb begin
    lanes_nxt     = lanes_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    cmd_nxt       = cmd_r;
    data_nxt      = data_r;
    round_nxt     = round_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    rc_ctrl.seed  = (fsm_nxt == ST_PERM) && (fsm_r != ST_PERM);
    rc_ctrl.step  = (fsm_r == ST_PERM);
    unique case (fsm_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = sks_cmd_t'(in_tuser);
          data_nxt = in_tdata;
          if ((sks_cmd_t'(in_tuser) != CMD_NONE) && (fill_r >= rate_eff)) begin
            fill_nxt = '0;
          end
        end
      end
      ST_ABSORB: begin
        if (cmd_r != CMD_FINAL) begin
          lanes_nxt[{fill_r, 3'b000} +: 8] = lanes_r[{fill_r, 3'b000} +: 8] ^ data_r;
          fill_nxt = fill_wrap ? 8'd0 : fill_r + 8'd1;
        end
      end
      ST_PAD: begin
        lanes_nxt[{fill_r, 3'b000} +: 8] = lanes_r[{fill_r, 3'b000} +: 8] ^ suffix_r;
      end
      ST_PAD_END: begin
        lanes_nxt[{rate_eff - 8'd1, 3'b000} +: 8] =
          lanes_r[{rate_eff - 8'd1, 3'b000} +: 8] ^ PAD_BYTE;
        idx_nxt = '0;
        k_nxt   = '0;
      end
      ST_PERM: begin
        lanes_nxt = round_out;
        round_nxt = (round_r == RND_W'(ROUNDS - 1)) ? '0 : round_r + RND_W'(1);
      end
      ST_SQUEEZE: begin
        if (idx_r == rate_eff) begin
          idx_nxt = '0;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = lanes_r[{idx_r, 3'b000} +: 8];
          out_last_nxt  = sq_last;
          idx_nxt       = idx_r + 8'd1;
          k_nxt         = k_r + 7'd1;
          if (sq_last) begin
            // digest done: fresh sponge for the next message
            lanes_nxt = '0;
            fill_nxt  = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= ST_IDLE;
      ret_r       <= ST_IDLE;
      lanes_r     <= '0;
      fill_r      <= '0;
      idx_r       <= '0;
      k_r         <= '0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r       <= fsm_nxt;
      ret_r       <= ret_nxt;
      lanes_r     <= lanes_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      k_r         <= k_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    data_r     <= data_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  sks_rc_lfsr u_rc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (rc_ctrl),
    .rc    (rc)
  );

  sks_round u_round (
    .state_in  (lanes_r),
    .rc        (rc),
    .state_out (round_out)
  );

`include "assert_macros.svh"

  `ASSERT_SYNC(a_fill_in_rate, fill_r < RATE_MAX, "block fill beyond max rate")
  `ASSERT_SYNC(a_round_only_perm, (round_r != '0) |-> (fsm_r == ST_PERM), "round outside perm")
  `ASSERT_SYNC(a_sq_count, (fsm_r == ST_SQUEEZE) |-> (k_r < n_eff), "digest count overrun")
  `ASSERT_SYNC(a_clear_last, sq_load && sq_last |=> !(|lanes_r) && fill_r == '0, "not cleared")

endmodule
